// ----- rtl/indexed_max_heap_scheduler_queue_macros.svh -----
// ----------------------------------------------------------------------------
// indexed_max_heap_scheduler_queue_macros
// Assertion macros for the indexed max-heap scheduler queue.
// ----------------------------------------------------------------------------
// Each macro expects clk and rst to be visible in the asserting module.
`ifndef INDEXED_MAX_HEAP_SCHEDULER_QUEUE_MACROS_SVH
`define INDEXED_MAX_HEAP_SCHEDULER_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IMHSQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("imhsq implication check failed");

// Next-cycle implication, disabled during reset.
`define IMHSQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("imhsq next-cycle check failed");

`endif

// ----- rtl/imhsq_pkg.sv -----
// ----------------------------------------------------------------------------
// imhsq_pkg
// Types, codes and constants shared by the heap scheduler queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package imhsq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int NUM_IDS      = 64;
  localparam int ID_W         = 6;
  localparam int TIME_W       = 32;
  localparam int KEY_W        = TIME_W + 1;
  localparam int COUNT_OUT_W  = 7;

  typedef enum logic [1:0] {
    OP_NOP    = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_INS_FAIL  = 2'd2,
    ST_RM_ABSENT = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_LOOK,
    S_LAST,
    S_UP_RD,
    S_UP_CMP,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_PLACE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ID_W-1:0]   proc_id;
    logic [TIME_W-1:0] duration;
    logic [TIME_W-1:0] now_time;
  } in_t;

  typedef struct packed {
    logic                   taken_valid;
    logic [ID_W-1:0]        taken_id;
    logic [TIME_W-1:0]      elapsed;
    logic                   top_valid;
    logic [ID_W-1:0]        top_id;
    logic [COUNT_OUT_W-1:0] count;
    logic [1:0]             status;
  } out_t;

  // One heap slot: owner id and its order key (duration + start)
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/imhsq_ram.sv -----
// ----------------------------------------------------------------------------
// imhsq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module imhsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/imhsq_engine.sv -----
// ----------------------------------------------------------------------------
// imhsq_engine
// Sequencer and key compares for insert, pop and remove with sifting.
// ----------------------------------------------------------------------------
`default_nettype none

module imhsq_engine #(
  parameter int CAPACITY = imhsq_pkg::CAPACITY_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire imhsq_pkg::in_t  in_data,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output imhsq_pkg::out_t      res_data
);

  localparam int SLOT_W     = $clog2(CAPACITY + 1);
  localparam int POS_W      = SLOT_W + 1;
  localparam int HEAP_DEPTH = CAPACITY + 1;
  localparam int ENTRY_W    = $bits(imhsq_pkg::entry_t);
  localparam int ID_W       = imhsq_pkg::ID_W;
  localparam int TIME_W     = imhsq_pkg::TIME_W;

  imhsq_pkg::state_e state, state_next;
  imhsq_pkg::in_t    req, req_next;
  imhsq_pkg::entry_t mov, mov_next;
  imhsq_pkg::entry_t lft, lft_next;
  imhsq_pkg::entry_t heap_rentry;
  imhsq_pkg::status_e status, status_next;

  logic [SLOT_W-1:0]       count, count_next;
  logic [SLOT_W-1:0]       pos, pos_next;
  logic [ID_W-1:0]         take_id, take_id_next;
  logic [ID_W-1:0]         top_id, top_id_next;
  logic                    taken, taken_next;
  logic [TIME_W-1:0]       elapsed, elapsed_next;
  logic [imhsq_pkg::NUM_IDS-1:0] vld, vld_next;

  logic                    heap_we;
  logic [SLOT_W-1:0]       heap_waddr, heap_raddr;
  imhsq_pkg::entry_t       heap_wentry;
  logic [ENTRY_W-1:0]      heap_rdata;
  logic                    slot_we;
  logic [ID_W-1:0]         slot_waddr, slot_raddr;
  logic [SLOT_W-1:0]       slot_wdata, slot_rdata;
  logic                    start_we;
  logic [ID_W-1:0]         start_raddr;
  logic [TIME_W-1:0]       start_rdata;

  logic [POS_W-1:0]        l_pos, r_pos, cnt_ext;
  logic                    l_in, r_in, go_r, go_l;

  assign heap_rentry = imhsq_pkg::entry_t'(heap_rdata);
  assign l_pos   = {pos, 1'b0};
  assign r_pos   = {pos, 1'b1};
  assign cnt_ext = {1'b0, count};
  assign l_in    = (l_pos <= cnt_ext);
  assign r_in    = (r_pos <= cnt_ext);
  assign go_r    = r_in && (lft.key < heap_rentry.key) && (mov.key < heap_rentry.key);
  assign go_l    = !go_r && (mov.key < lft.key);

  // Heap slots: id and key per slot, slot 1 is the top
  imhsq_ram #(.WIDTH(ENTRY_W), .DEPTH(HEAP_DEPTH)) u_heap_ram (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wentry),
    .raddr (heap_raddr),
    .rdata (heap_rdata)
  );

  // Slot of each id; presence lives in vld
  imhsq_ram #(.WIDTH(SLOT_W), .DEPTH(imhsq_pkg::NUM_IDS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // Start time of each id
  imhsq_ram #(.WIDTH(TIME_W), .DEPTH(imhsq_pkg::NUM_IDS)) u_start_ram (
    .clk   (clk),
    .we    (start_we),
    .waddr (req.proc_id),
    .wdata (req.now_time),
    .raddr (start_raddr),
    .rdata (start_rdata)
  );

  // State and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= imhsq_pkg::S_IDLE;
      count <= '0;
      vld   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      vld   <= vld_next;
    end
    req     <= req_next;
    mov     <= mov_next;
    lft     <= lft_next;
    pos     <= pos_next;
    take_id <= take_id_next;
    top_id  <= top_id_next;
    taken   <= taken_next;
    elapsed <= elapsed_next;
    status  <= status_next;
  end

  // Next state, memory controls and result
  always_comb begin
    state_next   = state;
    req_next     = req;
    mov_next     = mov;
    lft_next     = lft;
    pos_next     = pos;
    count_next   = count;
    take_id_next = take_id;
    top_id_next  = top_id;
    taken_next   = taken;
    elapsed_next = elapsed;
    status_next  = status;
    vld_next     = vld;
    heap_we      = 1'b0;
    heap_waddr   = pos;
    heap_wentry  = mov;
    heap_raddr   = count;
    slot_we      = 1'b0;
    slot_waddr   = mov.id;
    slot_wdata   = pos;
    slot_raddr   = req.proc_id;
    start_we     = 1'b0;
    start_raddr  = take_id;
    in_ready     = 1'b0;
    res_valid    = 1'b0;

    case (state)
      imhsq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_next     = in_data;
          taken_next   = 1'b0;
          elapsed_next = '0;
          status_next  = imhsq_pkg::ST_OK;
          state_next   = imhsq_pkg::S_DECODE;
        end
      end

      imhsq_pkg::S_DECODE: begin
        state_next = imhsq_pkg::S_DONE;
        case (imhsq_pkg::op_e'(req.opcode))
          imhsq_pkg::OP_INSERT: begin
            if ((count >= SLOT_W'(CAPACITY)) || vld[req.proc_id]) begin
              status_next = imhsq_pkg::ST_INS_FAIL;
            end else begin
              count_next             = count + 1'b1;
              pos_next               = count + 1'b1;
              mov_next.id            = req.proc_id;
              mov_next.key           = {1'b0, req.duration} + {1'b0, req.now_time};
              start_we               = 1'b1;
              vld_next[req.proc_id]  = 1'b1;
              state_next             = imhsq_pkg::S_UP_RD;
            end
          end
          imhsq_pkg::OP_POP: begin
            if (count == '0) begin
              status_next = imhsq_pkg::ST_POP_EMPTY;
            end else begin
              take_id_next = top_id;
              start_raddr  = top_id;
              heap_raddr   = count;
              pos_next     = SLOT_W'(1);
              state_next   = imhsq_pkg::S_LAST;
            end
          end
          imhsq_pkg::OP_REMOVE: begin
            if (!vld[req.proc_id]) begin
              status_next = imhsq_pkg::ST_RM_ABSENT;
            end else begin
              take_id_next = req.proc_id;
              slot_raddr   = req.proc_id;
              state_next   = imhsq_pkg::S_LOOK;
            end
          end
          default: begin
            state_next = imhsq_pkg::S_DONE;
          end
        endcase
      end

      // Slot of the id to remove is back; fetch last entry and start time
      imhsq_pkg::S_LOOK: begin
        pos_next    = slot_rdata;
        start_raddr = take_id;
        heap_raddr  = count;
        state_next  = imhsq_pkg::S_LAST;
      end

      // Drop the taken entry; the last entry moves into the hole
      imhsq_pkg::S_LAST: begin
        mov_next          = heap_rentry;
        taken_next        = 1'b1;
        elapsed_next      = (req.now_time >= start_rdata) ? (req.now_time - start_rdata) : '0;
        vld_next[take_id] = 1'b0;
        count_next        = count - 1'b1;
        state_next        = (pos == count) ? imhsq_pkg::S_DONE : imhsq_pkg::S_UP_RD;
      end

      imhsq_pkg::S_UP_RD: begin
        if (pos <= SLOT_W'(1)) begin
          state_next = (imhsq_pkg::op_e'(req.opcode) == imhsq_pkg::OP_INSERT) ?
                       imhsq_pkg::S_PLACE : imhsq_pkg::S_DN_L;
        end else begin
          heap_raddr = pos >> 1;
          state_next = imhsq_pkg::S_UP_CMP;
        end
      end

      // Move the parent down when its key is strictly smaller
      imhsq_pkg::S_UP_CMP: begin
        if (heap_rentry.key < mov.key) begin
          heap_we     = 1'b1;
          heap_wentry = heap_rentry;
          slot_we     = 1'b1;
          slot_waddr  = heap_rentry.id;
          pos_next    = pos >> 1;
          state_next  = imhsq_pkg::S_UP_RD;
        end else begin
          state_next = (imhsq_pkg::op_e'(req.opcode) == imhsq_pkg::OP_INSERT) ?
                       imhsq_pkg::S_PLACE : imhsq_pkg::S_DN_L;
        end
      end

      imhsq_pkg::S_DN_L: begin
        if (!l_in) begin
          state_next = imhsq_pkg::S_PLACE;
        end else begin
          heap_raddr = l_pos[SLOT_W-1:0];
          state_next = imhsq_pkg::S_DN_R;
        end
      end

      imhsq_pkg::S_DN_R: begin
        lft_next = heap_rentry;
        if (r_in) begin
          heap_raddr = r_pos[SLOT_W-1:0];
        end
        state_next = imhsq_pkg::S_DN_CMP;
      end

      // Pull the larger child up into the hole
      imhsq_pkg::S_DN_CMP: begin
        if (go_r) begin
          heap_we     = 1'b1;
          heap_wentry = heap_rentry;
          slot_we     = 1'b1;
          slot_waddr  = heap_rentry.id;
          pos_next    = r_pos[SLOT_W-1:0];
          state_next  = imhsq_pkg::S_DN_L;
        end else if (go_l) begin
          heap_we     = 1'b1;
          heap_wentry = lft;
          slot_we     = 1'b1;
          slot_waddr  = lft.id;
          pos_next    = l_pos[SLOT_W-1:0];
          state_next  = imhsq_pkg::S_DN_L;
        end else begin
          state_next = imhsq_pkg::S_PLACE;
        end
      end

      imhsq_pkg::S_PLACE: begin
        heap_we    = 1'b1;
        slot_we    = 1'b1;
        state_next = imhsq_pkg::S_DONE;
      end

      imhsq_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = imhsq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = imhsq_pkg::S_IDLE;
      end
    endcase

    // Track the top id on every write to slot 1
    if (heap_we && (heap_waddr == SLOT_W'(1))) begin
      top_id_next = heap_wentry.id;
    end
  end

  // Result fields
  always_comb begin
    res_data.taken_valid = taken;
    res_data.taken_id    = taken ? take_id : '0;
    res_data.elapsed     = elapsed;
    res_data.top_valid   = (count != '0);
    res_data.top_id      = (count != '0) ? top_id : '0;
    res_data.count       = imhsq_pkg::COUNT_OUT_W'(count);
    res_data.status      = status;
  end

endmodule

`default_nettype wire

// ----- rtl/indexed_max_heap_scheduler_queue.sv -----
// Indexed max-heap scheduler queue.
// Input channel in_valid/in_ready/in_data carries one transaction per command:
// nop, insert (id, duration, start = now_time), pop top, or remove by id.
// Output channel out_valid/out_ready/out_data returns exactly one result per
// command: the id taken out with its elapsed time, the top id, the entry
// count and a status code.
// The block handles one command at a time. Its run time is set by the sift
// walk over the single-read-port heap memory: nop and rejected commands skip
// the walk, insert climbs levels, pop moves levels down, and remove does the
// work of pop plus the levels moved up.
// The result sits in an output register, so a new command is accepted while
// an earlier result still waits; if the receiver stalls, the following
// result waits inside the block and in_ready stays low.
// Reset empties the queue and clears all id presence bits at once.
// ----------------------------------------------------------------------------
// indexed_max_heap_scheduler_queue
// Top level: command engine plus output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_max_heap_scheduler_queue_macros.svh"

module indexed_max_heap_scheduler_queue #(
  parameter int CAPACITY = imhsq_pkg::CAPACITY_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire imhsq_pkg::in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output imhsq_pkg::out_t      out_data
);

  logic            res_valid;
  logic            res_ready;
  imhsq_pkg::out_t res_data;

  imhsq_engine #(.CAPACITY(CAPACITY)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_data <= res_data;
    end
  end

  `IMHSQ_ASSERT_IMP(a_top_matches_count, out_valid, out_data.top_valid == (out_data.count != '0))
  `IMHSQ_ASSERT_IMP(a_taken_ok, out_valid && out_data.taken_valid, out_data.status == imhsq_pkg::ST_OK)
  `IMHSQ_ASSERT_IMP(a_count_bound, out_valid, out_data.count <= imhsq_pkg::NUM_IDS)
  `IMHSQ_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire
